>>> rtl/jsee_pkg.sv
// Package for the JSON string escape encoder.
// Holds byte codes, the descriptor type and the escape helper functions.
// No dependencies.
package jsee_pkg;

  localparam int BYTE_W     = 8;
  localparam int MAX_OUT    = 8;
  localparam int IDX_W      = $clog2(MAX_OUT);
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_NONE  = 8'h00;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t [MAX_OUT-1:0] text;
    logic [IDX_W-1:0]    last_idx;
  } desc_t;

  function automatic byte_t short_escape(input byte_t c);
    byte_t r;
    unique case (c)
      CH_QUOTE: r = CH_QUOTE;
      CH_BSL:   r = CH_BSL;
      CH_SLASH: r = CH_SLASH;
      8'h08:    r = 8'h62;
      8'h0C:    r = 8'h66;
      8'h0A:    r = 8'h6E;
      8'h0D:    r = 8'h72;
      8'h09:    r = 8'h74;
      default:  r = CH_NONE;
    endcase
    return r;
  endfunction

  function automatic byte_t hex_digit(input logic [3:0] v);
    byte_t r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_LA + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

endpackage

>>> rtl/jsee_in_if.sv
// Input channel of the escape encoder: one string byte with its marks.
// Depends on jsee_pkg.
interface jsee_in_if;
  import jsee_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  first_byte;
  logic  last_byte;
  logic  empty_string;
  modport source(output valid, data_byte, first_byte, last_byte, empty_string, input ready);
  modport sink(input valid, data_byte, first_byte, last_byte, empty_string, output ready);
endinterface

>>> rtl/jsee_out_if.sv
// Output channel of the escape encoder: one byte of escaped text.
// Depends on jsee_pkg.
interface jsee_out_if;
  import jsee_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_last;
  modport source(output valid, out_byte, run_last, input ready);
  modport sink(input valid, out_byte, run_last, output ready);
endinterface

>>> rtl/jsee_cfg_if.sv
// Configuration write channel carrying the no-escape register value.
// No dependencies.
interface jsee_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> rtl/jsee_front.sv
// Front end: accepts input bytes and expands each into an output descriptor.
// Depends on jsee_pkg and jsee_in_if.
module jsee_front (
  jsee_in_if.sink         in,
  input  logic            no_escape,
  input  logic            wr_ready,
  output logic            wr_valid,
  output jsee_pkg::desc_t wr_desc
);
  import jsee_pkg::*;

  byte_t             esc;
  logic [CNT_W-1:0]  n;

  assign in.ready = wr_ready;
  assign wr_valid = in.valid;
  assign esc      = short_escape(in.data_byte);

  always_comb begin
    wr_desc = '0;
    n = '0;
    if (in.empty_string) begin
      wr_desc.text[0] = CH_QUOTE;
      wr_desc.text[1] = CH_QUOTE;
      n = CNT_W'(2);
    end else begin
      if (in.first_byte) begin
        wr_desc.text[n[IDX_W-1:0]] = CH_QUOTE;
        n = n + 1'b1;
      end
      if (esc != CH_NONE) begin
        wr_desc.text[n[IDX_W-1:0]] = CH_BSL;
        n = n + 1'b1;
        wr_desc.text[n[IDX_W-1:0]] = esc;
        n = n + 1'b1;
      end else if (no_escape || (in.data_byte >= PRINT_LO && in.data_byte <= PRINT_HI)) begin
        wr_desc.text[n[IDX_W-1:0]] = in.data_byte;
        n = n + 1'b1;
      end else begin
        wr_desc.text[n[IDX_W-1:0]] = CH_BSL;
        n = n + 1'b1;
        wr_desc.text[n[IDX_W-1:0]] = CH_U;
        n = n + 1'b1;
        wr_desc.text[n[IDX_W-1:0]] = CH_ZERO;
        n = n + 1'b1;
        wr_desc.text[n[IDX_W-1:0]] = CH_ZERO;
        n = n + 1'b1;
        wr_desc.text[n[IDX_W-1:0]] = hex_digit(in.data_byte[7:4]);
        n = n + 1'b1;
        wr_desc.text[n[IDX_W-1:0]] = hex_digit(in.data_byte[3:0]);
        n = n + 1'b1;
      end
      if (in.last_byte) begin
        wr_desc.text[n[IDX_W-1:0]] = CH_QUOTE;
        n = n + 1'b1;
      end
    end
    wr_desc.last_idx = IDX_W'(n - 1'b1);
  end

endmodule

>>> rtl/jsee_queue.sv
// Short descriptor queue between the front and back ends.
// Depends on jsee_pkg.
module jsee_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  jsee_pkg::desc_t wr_desc,
  output logic            wr_ready,
  input  logic            pop,
  output logic            rd_valid,
  output jsee_pkg::desc_t rd_desc
);
  import jsee_pkg::*;

  desc_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign wr_ready = count != QCNT_W'(QDEPTH);
  assign push     = wr_valid && wr_ready;
  assign rd_valid = count != '0;
  assign rd_desc  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd_valid) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count lost a push");

endmodule

>>> rtl/jsee_back.sv
// Back end: walks each descriptor and emits one text byte per transfer.
// Depends on jsee_pkg and jsee_out_if.
module jsee_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_valid,
  input  jsee_pkg::desc_t rd_desc,
  output logic            pop,
  jsee_out_if.source      out
);
  import jsee_pkg::*;

  logic             out_valid;
  byte_t            out_byte;
  logic             run_last;
  logic [IDX_W-1:0] idx;
  logic             adv;
  logic             take;
  logic             at_end;

  assign adv          = !out_valid || out.ready;
  assign take         = adv && rd_valid;
  assign at_end       = idx == rd_desc.last_idx;
  assign pop          = take && at_end;
  assign out.valid    = out_valid;
  assign out.out_byte = out_byte;
  assign out.run_last = run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (adv) begin
      out_valid <= rd_valid;
      if (take) begin
        idx <= at_end ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= rd_desc.text[idx];
      run_last <= at_end;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> idx <= rd_desc.last_idx) else $error("index past descriptor end");
  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0) else $error("index not cleared after descriptor");
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    (take && !at_end) |-> !pop) else $error("early descriptor pop");

endmodule

>>> rtl/json_string_escape_encoder_core.sv
// An input transfer is queued, then its first output byte is registered.
// Throughput: one input byte per cycle for plain bytes while the output
// is ready; an item that expands to N output bytes (1 to 8) sends them
// one per transfer; a 2-deep queue decouples the two ends.
// Reset (rst, synchronous): clears no_escape, the queue and the output.
module json_string_escape_encoder_core (
  input  logic  clk,
  input  logic  rst,
  jsee_in_if.sink    in,
  jsee_out_if.source out,
  jsee_cfg_if.sink   cfg
);
  import jsee_pkg::*;

  logic  no_escape;
  logic  wr_valid;
  logic  wr_ready;
  desc_t wr_desc;
  logic  rd_valid;
  desc_t rd_desc;
  logic  pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_escape <= 1'b0;
    end else if (cfg.valid) begin
      no_escape <= cfg.data;
    end
  end

  jsee_front u_front (
    .in        (in),
    .no_escape (no_escape),
    .wr_ready  (wr_ready),
    .wr_valid  (wr_valid),
    .wr_desc   (wr_desc)
  );

  jsee_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_desc  (wr_desc),
    .wr_ready (wr_ready),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_desc  (rd_desc)
  );

  jsee_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_desc  (rd_desc),
    .pop      (pop),
    .out      (out)
  );

endmodule
